@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of the effect slot manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define ESM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("esm: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define ESM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("esm: next-cycle check failed");

`endif

@@ hdl/esm_pkg.sv @@
// Package with codes, defaults and shared types of the effect slot manager.
`timescale 1ns / 1ps

package esm_pkg;

  localparam int SLOTS_DEF        = 16;
  localparam int EFFECT_BYTES_DEF = 64;
  localparam int POOL_BYTES_DEF   = 1024;

  // Widest slot address over the supported range of slot counts.
  localparam int ADDR_W = 6;
  localparam int FLAG_W = 2;
  localparam int POOL_W = 12;

  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_EFFECT  = 3'd1;
  localparam logic [2:0] REQ_FREE    = 3'd2;
  localparam logic [2:0] REQ_CONTROL = 3'd3;
  localparam logic [2:0] REQ_GAIN    = 3'd4;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_SOLO  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  localparam logic [7:0] CTL_ENABLE   = 8'h01;
  localparam logic [7:0] CTL_DISABLE  = 8'h02;
  localparam logic [7:0] CTL_STOP_ALL = 8'h03;
  localparam logic [7:0] CTL_RESET    = 8'h04;
  localparam logic [7:0] CTL_PAUSE    = 8'h05;
  localparam logic [7:0] CTL_CONTINUE = 8'h06;

  localparam logic [7:0] FREE_ALL_IDX = 8'hFF;

  localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
  localparam logic [FLAG_W-1:0] FLAG_ALLOC = 2'b01;
  localparam logic [FLAG_W-1:0] FLAG_PLAY  = 2'b10;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic [7:0] GAIN_RESET = 8'hFF;

  // Access to the slot store for one cycle.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [FLAG_W-1:0] wr_data;
    logic              clr_all;
  } mem_req_t;

endpackage

@@ hdl/esm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module esm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/esm_slot_store.sv @@
// Slot flag store: RAM plus per-slot valid bits so that a clear empties every slot without walking the RAM.
`timescale 1ns / 1ps

module esm_slot_store #(
  parameter int SLOTS = esm_pkg::SLOTS_DEF,
  localparam int IW   = $clog2(SLOTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  esm_pkg::mem_req_t         req_i,
  output logic [esm_pkg::FLAG_W-1:0] rflags_o
);

  logic [SLOTS-1:0]           valid_q;
  logic                       rd_valid_q;
  logic [esm_pkg::FLAG_W-1:0] ram_rdata;
  logic [IW-1:0]              waddr;
  logic [IW-1:0]              raddr;

  assign waddr = req_i.wr_addr[IW-1:0];
  assign raddr = req_i.rd_addr[IW-1:0];

  esm_ram #(
    .WIDTH (esm_pkg::FLAG_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clr_all) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[raddr];
      end
    end
  end

  // A slot never written since the last clear reads as empty.
  assign rflags_o = rd_valid_q ? ram_rdata : esm_pkg::FLAG_NONE;

endmodule

@@ hdl/effect_slot_manager_unit.sv @@
// Top level of the effect slot manager: request sequencer around the slot store.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type, effect_index, operation,
//          |           |                         | control_code, gain_value
//  out     | output    | out_valid_o/out_stall_i | given_index, load_status, pool_left,
//          |           |                         | actuators_on, paused_flag, gain_now, slot_flags
//
// One request at a time; the slot RAM port is walked one entry per cycle.
// Simple requests pass through execute, flags and result, a single stop also through a stop
// state; create searches forward for the next free slot; stop all and start solo walk every
// slot. A finished result waits in the output register while the next request is taken.
// Reset: all slots empty, next free slot 1, pool full, actuators off, not paused, gain 255.
// A stalled output holds its payload; the sequencer waits in its last state until it drains.
`timescale 1ns / 1ps

module effect_slot_manager_unit #(
  parameter int SLOTS        = esm_pkg::SLOTS_DEF,
  parameter int EFFECT_BYTES = esm_pkg::EFFECT_BYTES_DEF,
  parameter int POOL_BYTES   = esm_pkg::POOL_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  effect_index_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  control_code_i,
  input  logic [7:0]  gain_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  given_index_o,
  output logic [1:0]  load_status_o,
  output logic [11:0] pool_left_o,
  output logic        actuators_on_o,
  output logic        paused_flag_o,
  output logic [7:0]  gain_now_o,
  output logic [1:0]  slot_flags_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int PW = esm_pkg::POOL_W;

  localparam logic [NW-1:0] SlotsN  = NW'(SLOTS);
  localparam logic [NW-1:0] LastN   = NW'(SLOTS - 1);
  localparam logic [NW-1:0] OneN    = NW'(1);
  localparam logic [7:0]    SlotsB  = 8'(SLOTS);
  localparam logic [PW-1:0] PoolMax = PW'(POOL_BYTES);
  localparam logic [PW-1:0] Effect  = PW'(EFFECT_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_WALK,
    ST_STOP,
    ST_START,
    ST_FLAGS,
    ST_RESULT
  } state_e;

  state_e                      state_q;
  logic [2:0]                  req_q;
  logic [7:0]                  idx_q;
  logic [1:0]                  op_q;
  logic [7:0]                  ctl_q;
  logic [7:0]                  gain_in_q;
  logic [NW-1:0]               nf_q;
  logic [PW-1:0]               pool_q;
  logic                        act_q;
  logic                        pause_q;
  logic [7:0]                  gain_q;
  logic [NW-1:0]               ptr_q;
  logic                        solo_q;
  logic [IW-1:0]               given_q;
  logic [1:0]                  status_q;
  logic [esm_pkg::FLAG_W-1:0]  flags_q;
  logic                        flags_mem_q;

  logic                        out_valid_q;
  logic [3:0]                  given_index_q;
  logic [1:0]                  load_status_q;
  logic [PW-1:0]               pool_left_q;
  logic                        actuators_on_q;
  logic                        paused_flag_q;
  logic [7:0]                  gain_now_q;
  logic [1:0]                  slot_flags_q;

  esm_pkg::mem_req_t           mem_req;
  logic [esm_pkg::FLAG_W-1:0]  rflags;
  logic                        in_range;
  logic [NW-1:0]               nf_inc;
  logic [NW-1:0]               ptr_inc;
  logic [PW:0]                 credit_sum;
  logic [PW-1:0]               pool_credit;
  logic [PW-1:0]               pool_debit;
  logic                        out_free;
  logic                        exec_walk;
  logic                        exec_stop;

  assign in_range    = idx_q < SlotsB;
  assign nf_inc      = nf_q + OneN;
  assign ptr_inc     = ptr_q + OneN;
  assign credit_sum  = {1'b0, pool_q} + {1'b0, Effect};
  assign pool_credit = (credit_sum > {1'b0, PoolMax}) ? PoolMax : credit_sum[PW-1:0];
  assign pool_debit  = (pool_q >= Effect) ? (pool_q - Effect) : '0;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Requests that walk every slot, and a single stop of a slot in range.
  assign exec_walk = ((req_q == esm_pkg::REQ_EFFECT) && (op_q == esm_pkg::OP_SOLO)) ||
                     ((req_q == esm_pkg::REQ_CONTROL) && (ctl_q == esm_pkg::CTL_STOP_ALL));
  assign exec_stop = (req_q == esm_pkg::REQ_EFFECT) && (op_q == esm_pkg::OP_STOP) && in_range;

  // Slot store accesses for the current step.
  always_comb begin
    mem_req = '0;
    case (state_q)
      ST_EXEC: begin
        case (req_q)
          esm_pkg::REQ_CREATE: begin
            if (nf_q < SlotsN) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = esm_pkg::ADDR_W'(nf_q[IW-1:0]);
              mem_req.wr_data = esm_pkg::FLAG_ALLOC;
              if (nf_inc < SlotsN) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = esm_pkg::ADDR_W'(nf_inc[IW-1:0]);
              end
            end
          end
          esm_pkg::REQ_EFFECT: begin
            case (op_q)
              esm_pkg::OP_START: begin
                mem_req.wr_en   = in_range;
                mem_req.wr_addr = esm_pkg::ADDR_W'(idx_q[IW-1:0]);
                mem_req.wr_data = esm_pkg::FLAG_PLAY;
              end
              esm_pkg::OP_SOLO: begin
                mem_req.rd_en = 1'b1;
              end
              esm_pkg::OP_STOP: begin
                mem_req.rd_en   = in_range;
                mem_req.rd_addr = esm_pkg::ADDR_W'(idx_q[IW-1:0]);
              end
              default: ;
            endcase
          end
          esm_pkg::REQ_FREE: begin
            if (idx_q == esm_pkg::FREE_ALL_IDX) begin
              mem_req.clr_all = 1'b1;
            end else begin
              mem_req.wr_en   = in_range;
              mem_req.wr_addr = esm_pkg::ADDR_W'(idx_q[IW-1:0]);
              mem_req.wr_data = esm_pkg::FLAG_NONE;
            end
          end
          esm_pkg::REQ_CONTROL: begin
            mem_req.rd_en   = (ctl_q == esm_pkg::CTL_STOP_ALL);
            mem_req.clr_all = (ctl_q == esm_pkg::CTL_RESET);
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        mem_req.rd_en   = (rflags != esm_pkg::FLAG_NONE) && (ptr_q != LastN);
        mem_req.rd_addr = esm_pkg::ADDR_W'(ptr_inc[IW-1:0]);
      end
      ST_WALK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = esm_pkg::ADDR_W'(ptr_q[IW-1:0]);
        mem_req.wr_data = rflags & esm_pkg::FLAG_ALLOC;
        mem_req.rd_en   = (ptr_q != LastN);
        mem_req.rd_addr = esm_pkg::ADDR_W'(ptr_inc[IW-1:0]);
      end
      ST_STOP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = esm_pkg::ADDR_W'(idx_q[IW-1:0]);
        mem_req.wr_data = rflags & esm_pkg::FLAG_ALLOC;
      end
      ST_START: begin
        mem_req.wr_en   = in_range;
        mem_req.wr_addr = esm_pkg::ADDR_W'(idx_q[IW-1:0]);
        mem_req.wr_data = esm_pkg::FLAG_PLAY;
      end
      ST_FLAGS: begin
        mem_req.rd_en   = in_range;
        mem_req.rd_addr = esm_pkg::ADDR_W'(idx_q[IW-1:0]);
      end
      default: ;
    endcase
  end

  esm_slot_store #(
    .SLOTS (SLOTS)
  ) u_slot_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rflags_o (rflags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      req_q          <= '0;
      idx_q          <= '0;
      op_q           <= '0;
      ctl_q          <= '0;
      gain_in_q      <= '0;
      nf_q           <= OneN;
      pool_q         <= PoolMax;
      act_q          <= 1'b0;
      pause_q        <= 1'b0;
      gain_q         <= esm_pkg::GAIN_RESET;
      ptr_q          <= '0;
      solo_q         <= 1'b0;
      given_q        <= '0;
      status_q       <= esm_pkg::STATUS_NONE;
      flags_q        <= esm_pkg::FLAG_NONE;
      flags_mem_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      given_index_q  <= '0;
      load_status_q  <= '0;
      pool_left_q    <= '0;
      actuators_on_q <= 1'b0;
      paused_flag_q  <= 1'b0;
      gain_now_q     <= '0;
      slot_flags_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q     <= req_type_i;
            idx_q     <= effect_index_i;
            op_q      <= operation_i;
            ctl_q     <= control_code_i;
            gain_in_q <= gain_value_i;
            state_q   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (req_q == esm_pkg::REQ_CREATE) begin
            flags_mem_q <= 1'b0;
            if (nf_q >= SlotsN) begin
              given_q  <= '0;
              status_q <= esm_pkg::STATUS_FULL;
              flags_q  <= esm_pkg::FLAG_NONE;
              state_q  <= ST_RESULT;
            end else begin
              given_q  <= nf_q[IW-1:0];
              status_q <= esm_pkg::STATUS_OK;
              flags_q  <= esm_pkg::FLAG_ALLOC;
              pool_q   <= pool_debit;
              ptr_q    <= nf_inc;
              if (nf_q == LastN) begin
                nf_q    <= SlotsN;
                state_q <= ST_RESULT;
              end else begin
                state_q <= ST_SCAN;
              end
            end
          end else begin
            given_q     <= '0;
            status_q    <= esm_pkg::STATUS_NONE;
            flags_mem_q <= 1'b1;
            state_q     <= exec_walk ? ST_WALK : (exec_stop ? ST_STOP : ST_FLAGS);
            case (req_q)
              esm_pkg::REQ_EFFECT: begin
                case (op_q)
                  esm_pkg::OP_SOLO: begin
                    solo_q <= 1'b1;
                    ptr_q  <= '0;
                  end
                  default: ;
                endcase
              end
              esm_pkg::REQ_FREE: begin
                if (idx_q == esm_pkg::FREE_ALL_IDX) begin
                  nf_q   <= OneN;
                  pool_q <= PoolMax;
                end else if (in_range && (idx_q < 8'(nf_q))) begin
                  // Slot 0 is reserved: the hint never drops below 1.
                  nf_q <= (idx_q == 8'd0) ? OneN : NW'(idx_q);
                end
              end
              esm_pkg::REQ_CONTROL: begin
                case (ctl_q)
                  esm_pkg::CTL_ENABLE:   act_q   <= 1'b1;
                  esm_pkg::CTL_DISABLE:  act_q   <= 1'b0;
                  esm_pkg::CTL_PAUSE:    pause_q <= 1'b1;
                  esm_pkg::CTL_CONTINUE: pause_q <= 1'b0;
                  esm_pkg::CTL_STOP_ALL: begin
                    solo_q <= 1'b0;
                    ptr_q  <= '0;
                  end
                  esm_pkg::CTL_RESET: begin
                    nf_q   <= OneN;
                    pool_q <= PoolMax;
                  end
                  default: ;
                endcase
              end
              esm_pkg::REQ_GAIN: begin
                gain_q <= gain_in_q;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rflags == esm_pkg::FLAG_NONE) begin
            nf_q    <= ptr_q;
            state_q <= ST_RESULT;
          end else if (ptr_q == LastN) begin
            nf_q    <= SlotsN;
            state_q <= ST_RESULT;
          end else begin
            ptr_q <= ptr_inc;
          end
        end
        ST_WALK: begin
          pool_q <= pool_credit;
          if (ptr_q == LastN) begin
            state_q <= solo_q ? ST_START : ST_FLAGS;
          end else begin
            ptr_q <= ptr_inc;
          end
        end
        ST_STOP: begin
          pool_q  <= pool_credit;
          state_q <= ST_FLAGS;
        end
        ST_START: begin
          state_q <= ST_FLAGS;
        end
        ST_FLAGS: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          // Hold until the output register is free or drains this cycle.
          if (out_free) begin
            out_valid_q    <= 1'b1;
            given_index_q  <= 4'(given_q);
            load_status_q  <= status_q;
            pool_left_q    <= pool_q;
            actuators_on_q <= act_q;
            paused_flag_q  <= pause_q;
            gain_now_q     <= gain_q;
            if (flags_mem_q) begin
              slot_flags_q <= in_range ? rflags : esm_pkg::FLAG_NONE;
            end else begin
              slot_flags_q <= flags_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign given_index_o  = given_index_q;
  assign load_status_o  = load_status_q;
  assign pool_left_o    = pool_left_q;
  assign actuators_on_o = actuators_on_q;
  assign paused_flag_o  = paused_flag_q;
  assign gain_now_o     = gain_now_q;
  assign slot_flags_o   = slot_flags_q;

endmodule

@@ hdl/esm_checker.sv @@
// Port-level checker of the effect slot manager and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module esm_checker #(
  parameter int POOL_BYTES = esm_pkg::POOL_BYTES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  given_index_o,
  input logic [1:0]  load_status_o,
  input logic [11:0] pool_left_o,
  input logic [1:0]  slot_flags_o
);

  `ESM_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ESM_ASSERT_IMP(a_pool_bounded, out_valid_o, pool_left_o <= 12'(POOL_BYTES))
  `ESM_ASSERT_IMP(a_no_grant_without_ok, out_valid_o && (load_status_o != esm_pkg::STATUS_OK), given_index_o == 4'd0)
  `ESM_ASSERT_IMP(a_grant_is_alloc, out_valid_o && (load_status_o == esm_pkg::STATUS_OK), slot_flags_o == esm_pkg::FLAG_ALLOC)
  `ESM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(pool_left_o) && $stable(slot_flags_o))

endmodule

bind effect_slot_manager_unit esm_checker #(.POOL_BYTES(POOL_BYTES)) u_esm_checker (.*);
